>>> rtl/cctc_pkg.sv
// Shared constants, types and the microcode table of the tick controller.
package cctc_pkg;

  localparam int ADC_BITS     = 10;
  localparam int ERROR_WIDTH  = 32;
  localparam int NUM_BITS     = 22;
  localparam int OFF_BITS     = 16;
  localparam int CORR_BITS    = 24;
  localparam int UPC_BITS     = 24;
  localparam int IVL_BITS     = 8;
  localparam int CMP_BITS     = 8;
  localparam int PULSE_BITS   = 2;
  localparam int DIV_CNT_BITS = $clog2(NUM_BITS);
  localparam int STEP_BITS    = 4;
  localparam int ADDR_BITS    = 5;
  localparam int IDX_BITS     = 3;
  localparam int IN_BYTES     = (2 + ADC_BITS + 7) / 8;
  localparam int IN_W         = IN_BYTES * 8;
  localparam int OUT_FIELDS_W = PULSE_BITS + 1 + 1 + CMP_BITS + 1 + CORR_BITS + ERROR_WIDTH;
  localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(NUM_BITS - 1);

  localparam logic [CMP_BITS-1:0] CMP_LONG  = CMP_BITS'(128);
  localparam logic [CMP_BITS-1:0] CMP_SHORT = CMP_BITS'(126);
  localparam logic [CMP_BITS-1:0] CMP_NOM   = CMP_BITS'(127);

  localparam logic [PULSE_BITS-1:0] PULSE_NONE   = PULSE_BITS'(0);
  localparam logic [PULSE_BITS-1:0] PULSE_SINGLE = PULSE_BITS'(1);
  localparam logic [PULSE_BITS-1:0] PULSE_DOUBLE = PULSE_BITS'(2);

  localparam logic [IDX_BITS-1:0] REG_NUMER  = IDX_BITS'(0);
  localparam logic [IDX_BITS-1:0] REG_OFFSET = IDX_BITS'(1);
  localparam logic [IDX_BITS-1:0] REG_THRESH = IDX_BITS'(2);
  localparam logic [IDX_BITS-1:0] REG_UPC    = IDX_BITS'(3);
  localparam logic [IDX_BITS-1:0] REG_NORM   = IDX_BITS'(4);
  localparam logic [IDX_BITS-1:0] REG_LOW    = IDX_BITS'(5);

  localparam logic [NUM_BITS-1:0] RST_NUMER  = NUM_BITS'(196866);
  localparam logic [OFF_BITS-1:0] RST_OFFSET = OFF_BITS'(-424);
  localparam logic [ADC_BITS-1:0] RST_THRESH = ADC_BITS'(420);
  localparam logic [UPC_BITS-1:0] RST_UPC    = UPC_BITS'(781250);
  localparam logic [IVL_BITS-1:0] RST_NORM   = IVL_BITS'(60);
  localparam logic [IVL_BITS-1:0] RST_LOW    = IVL_BITS'(5);

  typedef struct packed {
    logic [NUM_BITS-1:0] numer;
    logic [OFF_BITS-1:0] offset;
    logic [ADC_BITS-1:0] thresh;
    logic [UPC_BITS-1:0] upc;
    logic [IVL_BITS-1:0] norm_ivl;
    logic [IVL_BITS-1:0] low_ivl;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_LATCH, OP_DIV_INIT, OP_DIV_STEP, OP_SAMPLE, OP_CD_DEC,
    OP_TICK, OP_ADJUST, OP_STOP, OP_FAST, OP_EMIT
  } dp_op_e;

  typedef enum logic [2:0] {
    C_NEVER, C_ALWAYS, C_NO_ITEM, C_STOP, C_FAST, C_CD_NZ, C_DIV_MORE, C_OUT_BUSY
  } jump_cond_e;

  typedef struct packed {
    dp_op_e                 op;
    jump_cond_e             cond;
    logic [STEP_BITS-1:0]   target;
  } ucode_t;

  typedef struct packed {
    logic in_valid;
    logic stop;
    logic fast;
    logic cd_nz;
    logic div_more;
    logic out_busy;
  } dp_status_t;

  localparam logic [STEP_BITS-1:0] S_WAIT   = STEP_BITS'(0);
  localparam logic [STEP_BITS-1:0] S_STOPCK = STEP_BITS'(1);
  localparam logic [STEP_BITS-1:0] S_FASTCK = STEP_BITS'(2);
  localparam logic [STEP_BITS-1:0] S_CDCK   = STEP_BITS'(3);
  localparam logic [STEP_BITS-1:0] S_DINIT  = STEP_BITS'(4);
  localparam logic [STEP_BITS-1:0] S_DSTEP  = STEP_BITS'(5);
  localparam logic [STEP_BITS-1:0] S_SAMPLE = STEP_BITS'(6);
  localparam logic [STEP_BITS-1:0] S_CDDEC  = STEP_BITS'(7);
  localparam logic [STEP_BITS-1:0] S_TICK   = STEP_BITS'(8);
  localparam logic [STEP_BITS-1:0] S_ADJ    = STEP_BITS'(9);
  localparam logic [STEP_BITS-1:0] S_STOP   = STEP_BITS'(10);
  localparam logic [STEP_BITS-1:0] S_FAST   = STEP_BITS'(11);
  localparam logic [STEP_BITS-1:0] S_OWAIT  = STEP_BITS'(12);
  localparam logic [STEP_BITS-1:0] S_EMIT   = STEP_BITS'(13);

  function automatic ucode_t ucode_rom(logic [STEP_BITS-1:0] step);
    ucode_t w;
    case (step)
      S_WAIT:   w = '{op: OP_LATCH,    cond: C_NO_ITEM,  target: S_WAIT};
      S_STOPCK: w = '{op: OP_NOP,      cond: C_STOP,     target: S_STOP};
      S_FASTCK: w = '{op: OP_NOP,      cond: C_FAST,     target: S_FAST};
      S_CDCK:   w = '{op: OP_NOP,      cond: C_CD_NZ,    target: S_CDDEC};
      S_DINIT:  w = '{op: OP_DIV_INIT, cond: C_NEVER,    target: S_WAIT};
      S_DSTEP:  w = '{op: OP_DIV_STEP, cond: C_DIV_MORE, target: S_DSTEP};
      S_SAMPLE: w = '{op: OP_SAMPLE,   cond: C_ALWAYS,   target: S_TICK};
      S_CDDEC:  w = '{op: OP_CD_DEC,   cond: C_NEVER,    target: S_WAIT};
      S_TICK:   w = '{op: OP_TICK,     cond: C_NEVER,    target: S_WAIT};
      S_ADJ:    w = '{op: OP_ADJUST,   cond: C_ALWAYS,   target: S_OWAIT};
      S_STOP:   w = '{op: OP_STOP,     cond: C_ALWAYS,   target: S_OWAIT};
      S_FAST:   w = '{op: OP_FAST,     cond: C_NEVER,    target: S_WAIT};
      S_OWAIT:  w = '{op: OP_NOP,      cond: C_OUT_BUSY, target: S_OWAIT};
      S_EMIT:   w = '{op: OP_EMIT,     cond: C_ALWAYS,   target: S_WAIT};
      default:  w = '{op: OP_NOP,      cond: C_ALWAYS,   target: S_WAIT};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/compensated_clock_tick_controller.sv
// Top level of the compensated clock tick controller.
//
//   channel  direction  handshake                  payload
//   s_axis   in         s_axis_tvalid/tready       stop, fast, adc sample
//   m_axis   out        m_axis_tvalid/tready       pulses, pin, hold, compare, flags, error
//   apb      in/out     psel/penable/pready        six configuration registers
//
// A stop tick runs the stop step, a fast tick the fast step, a tick that only counts
// down the countdown, tick and adjust steps, and a sampling tick the 22-step restoring
// divide, sample, tick and adjust steps; each waits while m_axis holds an unread result.
// Reset is asynchronous and active low; no clearing pass is needed.
// One item is in work at a time; s_axis_tready is high only while waiting.
module compensated_clock_tick_controller
  import cctc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_W-1:0]      s_axis_tdata,   // stop_pressed, fast_pressed, adc_sample
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OUT_W-1:0]     m_axis_tdata,   // pulse_count, first_pin, hold_counter,
                                               // next_compare, voltage_low,
                                               // correction_now, error_now
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  cfg_t       cfg;
  ucode_t     ctrl;
  dp_status_t status;

  assign s_axis_tready = (ctrl.op == OP_LATCH);

  cctc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cctc_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  cctc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_data_i   (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .status_o    (status)
  );

endmodule

>>> rtl/cctc_regs.sv
// APB configuration register file of the tick controller.
module cctc_regs
  import cctc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output cfg_t                 cfg_o
);

  cfg_t                cfg_q, cfg_d;
  logic [IDX_BITS-1:0] idx;
  logic                wr_en;

  assign idx    = paddr[ADDR_BITS-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_NUMER:  cfg_d.numer    = pwdata[NUM_BITS-1:0];
        REG_OFFSET: cfg_d.offset   = pwdata[OFF_BITS-1:0];
        REG_THRESH: cfg_d.thresh   = pwdata[ADC_BITS-1:0];
        REG_UPC:    cfg_d.upc      = pwdata[UPC_BITS-1:0];
        REG_NORM:   cfg_d.norm_ivl = pwdata[IVL_BITS-1:0];
        REG_LOW:    cfg_d.low_ivl  = pwdata[IVL_BITS-1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_NUMER:  prdata = {{(32-NUM_BITS){1'b0}}, cfg_q.numer};
      REG_OFFSET: prdata = {{(32-OFF_BITS){cfg_q.offset[OFF_BITS-1]}}, cfg_q.offset};
      REG_THRESH: prdata = {{(32-ADC_BITS){1'b0}}, cfg_q.thresh};
      REG_UPC:    prdata = {{(32-UPC_BITS){1'b0}}, cfg_q.upc};
      REG_NORM:   prdata = {{(32-IVL_BITS){1'b0}}, cfg_q.norm_ivl};
      REG_LOW:    prdata = {{(32-IVL_BITS){1'b0}}, cfg_q.low_ivl};
      default:    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{numer: RST_NUMER, offset: RST_OFFSET, thresh: RST_THRESH,
                 upc: RST_UPC, norm_ivl: RST_NORM, low_ivl: RST_LOW};
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> rtl/cctc_seq.sv
// Microcode step counter with conditional jumps.
module cctc_seq
  import cctc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_status_t status_i,
  output ucode_t     ctrl_o
);

  logic [STEP_BITS-1:0] step_q, step_d;
  ucode_t               word;
  logic                 take;

  assign word   = ucode_rom(step_q);
  assign ctrl_o = word;

  always_comb begin
    case (word.cond)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_ITEM:  take = ~status_i.in_valid;
      C_STOP:     take = status_i.stop;
      C_FAST:     take = status_i.fast;
      C_CD_NZ:    take = status_i.cd_nz;
      C_DIV_MORE: take = status_i.div_more;
      C_OUT_BUSY: take = status_i.out_busy;
      default:    take = 1'b0;
    endcase
    step_d = take ? word.target : step_q + STEP_BITS'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_WAIT;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

>>> rtl/cctc_dp.sv
// Datapath: divider, correction, error accumulator and output register.
module cctc_dp
  import cctc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ucode_t              ctrl_i,
  input  cfg_t                cfg_i,
  input  logic                in_valid_i,
  input  logic [IN_W-1:0]     in_data_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [OUT_W-1:0]    out_data_o,
  output dp_status_t          status_o
);

  logic                   stop_q, fast_q;
  logic [ADC_BITS-1:0]    sample_q;
  logic [NUM_BITS-1:0]    quot_q;
  logic [ADC_BITS-1:0]    rem_q;
  logic [DIV_CNT_BITS-1:0] cnt_q;
  logic [CORR_BITS-1:0]   corr_q;
  logic                   low_q;
  logic [IVL_BITS-1:0]    cd_q;
  logic                   skip_q;
  logic [ERROR_WIDTH-1:0] err_q;
  logic [CMP_BITS-1:0]    cmp_q;
  logic                   motor_q;
  logic [PULSE_BITS-1:0]  pulses_q;
  logic                   hold_q;
  logic                   out_valid_q;
  logic [OUT_W-1:0]       out_data_q;

  logic [ADC_BITS:0]        rem_sh, rem_diff;
  logic                     ge;
  logic [NUM_BITS-1:0]      q_eff;
  logic [CORR_BITS-1:0]     corr_new;
  logic                     low_new;
  logic [ERROR_WIDTH-1:0]   err_sum, err_up, err_dn, upc_ext;
  logic signed [ERROR_WIDTH:0] e_x, stp_x, nstp_x;
  logic                     emit;

  assign rem_sh   = {rem_q, quot_q[NUM_BITS-1]};
  assign rem_diff = rem_sh - {1'b0, sample_q};
  assign ge       = (rem_sh >= {1'b0, sample_q});

  assign q_eff    = (sample_q != '0) ? quot_q : '0;
  assign corr_new = {{(CORR_BITS-NUM_BITS){1'b0}}, q_eff}
                  + {{(CORR_BITS-OFF_BITS){cfg_i.offset[OFF_BITS-1]}}, cfg_i.offset};
  assign low_new  = (sample_q > cfg_i.thresh);

  assign err_sum  = err_q + {{(ERROR_WIDTH-CORR_BITS){corr_q[CORR_BITS-1]}}, corr_q};
  assign upc_ext  = {{(ERROR_WIDTH-UPC_BITS){1'b0}}, cfg_i.upc};
  assign err_dn   = err_q - upc_ext;
  assign err_up   = err_q + upc_ext;
  assign e_x      = $signed({err_q[ERROR_WIDTH-1], err_q});
  assign stp_x    = $signed({{(ERROR_WIDTH+1-UPC_BITS){1'b0}}, cfg_i.upc});
  assign nstp_x   = -stp_x;

  assign emit        = (ctrl_i.op == OP_EMIT);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign status_o = '{in_valid: in_valid_i, stop: stop_q, fast: fast_q,
                      cd_nz: (cd_q != '0), div_more: (cnt_q != DIV_LAST),
                      out_busy: out_valid_q & ~out_ready_i};

  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      OP_LATCH: begin
        if (in_valid_i) begin
          stop_q   <= in_data_i[0];
          fast_q   <= in_data_i[1];
          sample_q <= in_data_i[ADC_BITS+1:2];
        end
      end
      OP_DIV_INIT: begin
        quot_q <= cfg_i.numer;
        rem_q  <= '0;
        cnt_q  <= '0;
      end
      OP_DIV_STEP: begin
        quot_q <= {quot_q[NUM_BITS-2:0], ge};
        rem_q  <= ge ? rem_diff[ADC_BITS-1:0] : rem_sh[ADC_BITS-1:0];
        cnt_q  <= cnt_q + DIV_CNT_BITS'(1);
      end
      OP_TICK: begin
        hold_q <= 1'b0;
        if (skip_q) begin
          pulses_q <= PULSE_DOUBLE;
        end else if (low_q) begin
          pulses_q <= PULSE_NONE;
        end else begin
          pulses_q <= PULSE_SINGLE;
        end
      end
      OP_STOP: begin
        hold_q   <= 1'b1;
        pulses_q <= PULSE_NONE;
      end
      OP_FAST: begin
        hold_q   <= 1'b0;
        pulses_q <= PULSE_DOUBLE;
      end
      default: begin
        hold_q <= hold_q;
      end
    endcase
    if (emit) begin
      out_data_q <= {{(OUT_W-OUT_FIELDS_W){1'b0}}, err_q, corr_q, low_q, cmp_q,
                     hold_q, motor_q, pulses_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corr_q      <= '0;
      low_q       <= 1'b0;
      cd_q        <= '0;
      skip_q      <= 1'b0;
      err_q       <= '0;
      cmp_q       <= CMP_NOM;
      motor_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      case (ctrl_i.op)
        OP_SAMPLE: begin
          corr_q <= corr_new;
          low_q  <= low_new;
          cd_q   <= low_new ? cfg_i.low_ivl : cfg_i.norm_ivl;
        end
        OP_CD_DEC: begin
          cd_q <= cd_q - IVL_BITS'(1);
        end
        OP_TICK: begin
          err_q <= err_sum;
          if (skip_q) begin
            skip_q <= 1'b0;
          end else if (low_q) begin
            skip_q <= 1'b1;
          end
        end
        OP_ADJUST: begin
          if (e_x >= stp_x) begin
            err_q <= err_dn;
            cmp_q <= CMP_LONG;
          end else if (e_x <= nstp_x) begin
            err_q <= err_up;
            cmp_q <= CMP_SHORT;
          end else begin
            cmp_q <= CMP_NOM;
          end
        end
        OP_STOP, OP_FAST: begin
          err_q  <= '0;
          skip_q <= 1'b0;
        end
        OP_EMIT: begin
          motor_q <= motor_q ^ pulses_q[0];
        end
        default: begin
          cd_q <= cd_q;
        end
      endcase
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule
